FILE: rtl/fna_pkg.sv
// shared widths, command/status structs and controller states for the norm accumulator
// no dependencies; imported by every module of the block
`default_nettype none

package fna_pkg;

    // element and accumulator widths
    localparam int ELEM_W    = 24;
    localparam int ACC_W     = 64;
    // derived widths
    localparam int MAG_W     = ELEM_W + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
    localparam int ROOT_W    = (ACC_W + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int CNT_W     = $clog2(ROOT_W);
    // stream payload widths
    localparam int S_DATA_W  = ((2 * ELEM_W + 7) / 8) * 8;
    localparam int NORM_W    = 32;
    localparam int CFG_W     = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic capture;   // latch the request operands
        logic square;    // register the product
        logic accum;     // saturating add into the sum
        logic root_go;   // start the square root
        logic push;      // load the output register, clear the sum
    } t_dp_cmd;

    typedef struct packed {
        logic last;      // the captured request closes a matrix
        logic root_done; // square root result ready
        logic out_free;  // output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/fna_sqrt.sv
// iterative floor square root, one result bit per cycle
// depends on fna_pkg
`default_nettype none

module fna_sqrt (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [fna_pkg::RAD_W-1:0] i_radicand,
    output logic                      o_done,
    output logic [fna_pkg::ROOT_W-1:0] o_root
);
    import fna_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;

    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               fits;
    logic [REM_W-1:0]   n_rem;
    logic [ROOT_W-1:0]  n_root;

    // restoring step: bring down two radicand bits, try 4*root+1
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {r_root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: rtl/fna_datapath.sv
// operand capture, squarer, saturating accumulator, square root and output register
// depends on fna_pkg and fna_sqrt
`default_nettype none

module fna_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire  [fna_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire  [fna_pkg::S_DATA_W-1:0] i_s_data,
    input  wire                          i_s_last,
    input  fna_pkg::t_dp_cmd             i_cmd,
    output fna_pkg::t_dp_status          o_status,
    input  wire                          i_m_ready,
    output logic                         o_m_valid,
    output logic [fna_pkg::NORM_W-1:0]   o_m_norm,
    output logic                         o_m_sat
);
    import fna_pkg::*;

    logic               r_mode;
    logic               r_last;
    logic [MAG_W-1:0]   r_mag;
    logic [SQ_W-1:0]    r_sq;
    logic [ACC_W-1:0]   r_acc;
    logic               r_ovf;
    logic               r_out_valid;
    logic [NORM_W-1:0]  r_norm;
    logic               r_sat;

    logic [MAG_W-1:0]   a_ext;
    logic [MAG_W-1:0]   b_ext;
    logic [MAG_W-1:0]   diff;
    logic [MAG_W-1:0]   mag;
    logic [SQ_W-1:0]    sq;
    logic [SUM_W-1:0]   sum;
    logic               sum_ovf;
    logic               out_free;
    logic               root_done;
    logic [ROOT_W-1:0]  root;

    // sign-extend both elements by one bit so the difference cannot wrap
    always_comb begin
        a_ext = {i_s_data[ELEM_W-1], i_s_data[ELEM_W-1:0]};
        b_ext = {i_s_data[2*ELEM_W-1], i_s_data[2*ELEM_W-1:ELEM_W]};
        diff  = r_mode ? (a_ext - b_ext) : a_ext;
        mag   = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    end

    assign sq      = r_mag * r_mag;
    assign sum     = SUM_W'(r_acc) + SUM_W'(r_sq);
    assign sum_ovf = |sum[SUM_W-1:ACC_W];
    assign out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mag  <= mag;
            r_last <= i_s_last;
        end
        if (i_cmd.square) begin
            r_sq <= sq;
        end
    end

    // sum sticks at all ones once it overflows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.push) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accum) begin
            if (sum_ovf) begin
                r_acc <= '1;
                r_ovf <= 1'b1;
            end else begin
                r_acc <= sum[ACC_W-1:0];
            end
        end
    end

    fna_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_go),
        .i_radicand (RAD_W'(r_acc)),
        .o_done     (root_done),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_norm <= NORM_W'(root);
            r_sat  <= r_ovf;
        end
    end

    always_comb begin
        o_status.last      = r_last;
        o_status.root_done = root_done;
        o_status.out_free  = out_free;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_norm  = r_norm;
    assign o_m_sat   = r_sat;

endmodule

`default_nettype wire

FILE: rtl/fna_ctrl.sv
// controller state machine sequencing capture, square, accumulate, square root and output load
// depends on fna_pkg
`default_nettype none

module fna_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_valid,
    output logic                o_s_ready,
    input  fna_pkg::t_dp_status i_status,
    output fna_pkg::t_dp_cmd    o_cmd
);
    import fna_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                n_state = i_status.last ? ST_ROOT_GO : ST_IDLE;
            end
            ST_ROOT_GO: begin
                n_state = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (i_status.root_done) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready     = (r_state == ST_IDLE);
        o_cmd.capture = (r_state == ST_IDLE) && i_s_valid;
        o_cmd.square  = (r_state == ST_SQUARE);
        o_cmd.accum   = (r_state == ST_ACCUM);
        o_cmd.root_go = (r_state == ST_ROOT_GO);
        o_cmd.push    = (r_state == ST_PUSH) && i_status.out_free;
    end

endmodule

`default_nettype wire

FILE: rtl/frobenius_norm_accumulator.sv
// top level of the frobenius norm accumulator
// depends on fna_pkg, fna_ctrl, fna_datapath (and fna_sqrt below it)
`default_nettype none

// Sums the squares of matrix elements (or of element differences a - b when
// difference mode is set) in a 64-bit accumulator that sticks at all ones on
// overflow, and on the request flagged tlast returns the floor square root of
// the sum with a saturation flag, then clears the sum for the next matrix.
// Each request passes through capture and magnitude, one registered
// 25x25 multiply and one saturating 64-bit add; tready is high again right after.
// A request that closes a matrix then runs the square root, which produces one
// result bit per cycle in a single restoring unit (32 iterations plus start,
// done and output load), so it holds tready low until its result is loaded.
// The result sits in an output register, so the next matrix can start
// streaming while that result waits for tready; only a second finished result
// stalls until the first has been taken. The user must write difference_mode
// through i_cfg_wr_en/i_cfg_wr_data only while idle; the block does not enforce this.

module frobenius_norm_accumulator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration: difference_mode in bit 0
    input  wire                          i_cfg_wr_en,
    input  wire  [fna_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // element requests
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [fna_pkg::S_DATA_W-1:0] s_axis_tdata,  // elem_a, elem_b
    input  wire                          s_axis_tlast,  // last_element
    // norm results
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [fna_pkg::NORM_W-1:0]   m_axis_tdata,  // norm_value
    output logic                         m_axis_tuser   // saturated
);
    import fna_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing of one request and of the square root
    fna_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // arithmetic and the result register
    fna_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_data      (s_axis_tdata),
        .i_s_last      (s_axis_tlast),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_m_norm      (m_axis_tdata),
        .o_m_sat       (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/fna_checker.sv
// port-level checks for the norm accumulator, bound to the top level
// depends on fna_pkg and frobenius_norm_accumulator
`default_nettype none

module fna_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [fna_pkg::NORM_W-1:0]    m_axis_tdata,
    input wire                          m_axis_tuser
);
    import fna_pkg::*;

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time: the square and add follow every accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request accepted during square and add");

    // a result never appears straight after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_acc))
        else $error("result appeared too early");

endmodule

bind frobenius_norm_accumulator fna_checker u_fna_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
